[rtl/lmtf_pkg.sv]
// shared constants and types for the move-to-front key store
`default_nettype none

package lmtf_pkg;

    localparam int DEPTH_DEF    = 8;
    localparam int KEY_BITS_DEF = 32;

    localparam int          CAP_W     = 4;
    localparam logic [3:0]  CAP_RESET = 4'd8;
    localparam int          HP_W      = 3;
    localparam int          OCC_W     = 4;

    localparam int USER_W     = 2;
    localparam int USER_HIT   = 0;
    localparam int USER_EVICT = 1;

    typedef struct packed {
        logic valid;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic found;
        logic first;
    } t_cell_stat;

endpackage

`default_nettype wire

[rtl/lmtf_cell.sv]
// one entry of the recency list: key register, compare and shift
`default_nettype none

module lmtf_cell
    import lmtf_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire  [KEY_BITS-1:0] i_key,
    input  wire  [KEY_BITS-1:0] i_prev_key,
    input  wire                 i_found,
    input  t_cell_ctl           i_ctl,
    output t_cell_stat          o_stat,
    output logic [KEY_BITS-1:0] o_key
);

    logic [KEY_BITS-1:0] r_key;
    logic                w_match;

    assign w_match      = i_ctl.valid && (r_key == i_key);
    assign o_stat.first = w_match && !i_found;
    assign o_stat.found = w_match || i_found;
    assign o_key        = r_key;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key <= i_prev_key;
        end
    end

endmodule

`default_nettype wire

[rtl/lru_move_to_front_cache.sv]
// top level of the move-to-front lru key store
// usage:
//   s_axis carries one key per word in tdata (key in the low bits).
//   m_axis returns one result word per key: tuser[0] hit, tuser[1] evicted;
//   tdata holds hit position, evicted key and occupancy after the access.
//   i_cfg_we/i_cfg_wdata write the capacity in use (0 acts as 1, values
//   above DEPTH act as DEPTH); write it only while no word is in flight.
// timing:
//   one key is taken per cycle while m_axis is not stalled; its result is
//   registered and shows on m_axis the cycle after acceptance. The row of
//   cells compares all entries in parallel and shifts the list in that same
//   cycle, through the compare, first-match chain and shift mux.
// reset:
//   the list is emptied (occupancy 0) and the capacity returns to 8;
//   stored keys are not cleared, entries beyond occupancy are never read.
// stall:
//   while a result waits on m_axis, s_axis_tready stays low unless the
//   result is taken in the same cycle; nothing is dropped.
`default_nettype none

module lru_move_to_front_cache
    import lmtf_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    localparam int IN_DW   = ((KEY_BITS + 7) / 8) * 8,
    localparam int OUT_DW  = ((HP_W + KEY_BITS + OCC_W + 7) / 8) * 8
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire  [CAP_W-1:0]   i_cfg_wdata,
    input  wire                i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire  [IN_DW-1:0]   i_s_axis_tdata,  // key
    output logic               o_m_axis_tvalid,
    input  wire                i_m_axis_tready,
    output logic [OUT_DW-1:0]  o_m_axis_tdata,  // hit_position, evicted_key, occupancy
    output logic [USER_W-1:0]  o_m_axis_tuser   // hit, evicted
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]    r_cap;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_out_valid;
    logic                r_hit, r_evict;
    logic [HP_W-1:0]     r_hit_pos;
    logic [KEY_BITS-1:0] r_ev_key;
    logic [OCC_W-1:0]    r_occ;

    logic [KEY_BITS-1:0] w_key;
    logic                w_accept;
    logic [CMP_W-1:0]    w_cap_ext;
    logic [CNT_W-1:0]    w_eff_cap;
    logic                w_hit, w_full, w_evict;
    logic [IDX_W-1:0]    w_hit_idx, w_pos, w_ev_idx;
    logic [KEY_BITS-1:0] w_ev_key;

    t_cell_ctl           w_ctl  [DEPTH];
    t_cell_stat          w_stat [DEPTH];
    logic [KEY_BITS-1:0] w_cell_key [DEPTH];

    assign w_key           = i_s_axis_tdata[KEY_BITS-1:0];
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // effective capacity
    always_comb begin
        w_cap_ext = CMP_W'(r_cap);
        if (w_cap_ext == '0) begin
            w_eff_cap = CNT_W'(1);
        end else if (w_cap_ext > CMP_W'(DEPTH)) begin
            w_eff_cap = CNT_W'(DEPTH);
        end else begin
            w_eff_cap = CNT_W'(w_cap_ext);
        end
    end

    assign w_hit    = w_stat[DEPTH-1].found;
    assign w_full   = r_count >= w_eff_cap;
    assign w_evict  = !w_hit && w_full;
    assign w_ev_idx = IDX_W'(w_eff_cap - CNT_W'(1));

    always_comb begin
        w_hit_idx = '0;
        w_ev_key  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_stat[i].first) begin
                w_hit_idx = w_hit_idx | IDX_W'(i);
            end
            if (w_ev_idx == IDX_W'(i)) begin
                w_ev_key = w_ev_key | w_cell_key[i];
            end
        end
        if (!w_evict) begin
            w_ev_key = '0;
        end
    end

    always_comb begin
        if (w_hit) begin
            w_pos   = w_hit_idx;
            n_count = r_count;
        end else if (!w_full) begin
            w_pos   = IDX_W'(r_count);
            n_count = r_count + CNT_W'(1);
        end else begin
            w_pos   = w_ev_idx;
            n_count = w_eff_cap;
        end
    end

    // row of cells, cell 0 is most recent
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_ctl[g].valid = CNT_W'(g) < r_count;
        assign w_ctl[g].shift = w_accept && (IDX_W'(g) <= w_pos);

        if (g == 0) begin : g_head
            lmtf_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                .i_clk      (i_clk),
                .i_key      (w_key),
                .i_prev_key (w_key),
                .i_found    (1'b0),
                .i_ctl      (w_ctl[g]),
                .o_stat     (w_stat[g]),
                .o_key      (w_cell_key[g])
            );
        end else begin : g_body
            lmtf_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                .i_clk      (i_clk),
                .i_key      (w_key),
                .i_prev_key (w_cell_key[g-1]),
                .i_found    (w_stat[g-1].found),
                .i_ctl      (w_ctl[g]),
                .o_stat     (w_stat[g]),
                .o_key      (w_cell_key[g])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit     <= w_hit;
            r_hit_pos <= w_hit ? HP_W'(w_hit_idx) : '0;
            r_evict   <= w_evict;
            r_ev_key  <= w_ev_key;
            r_occ     <= OCC_W'(n_count);
        end
    end

    assign o_m_axis_tvalid            = r_out_valid;
    assign o_m_axis_tuser[USER_HIT]   = r_hit;
    assign o_m_axis_tuser[USER_EVICT] = r_evict;
    assign o_m_axis_tdata = OUT_DW'({r_occ, r_ev_key, r_hit_pos});

endmodule

`default_nettype wire

[rtl/lmtf_checker.sv]
// port-level checks for the move-to-front key store, bound to the top level
`default_nettype none

module lmtf_checker
    import lmtf_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF,
    localparam int OUT_DW  = ((HP_W + KEY_BITS + OCC_W + 7) / 8) * 8
) (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               o_m_axis_tvalid,
    input wire               i_m_axis_tready,
    input wire [OUT_DW-1:0]  o_m_axis_tdata,
    input wire [USER_W-1:0]  o_m_axis_tuser
);

    logic             w_hit, w_evict;
    logic [HP_W-1:0]  w_hit_pos;
    logic [KEY_BITS-1:0] w_ev_key;
    logic [OCC_W-1:0] w_occ;

    assign w_hit     = o_m_axis_tuser[USER_HIT];
    assign w_evict   = o_m_axis_tuser[USER_EVICT];
    assign w_hit_pos = o_m_axis_tdata[HP_W-1:0];
    assign w_ev_key  = o_m_axis_tdata[HP_W +: KEY_BITS];
    assign w_occ     = o_m_axis_tdata[HP_W + KEY_BITS +: OCC_W];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(w_hit && w_evict))
        else $error("hit and eviction in one result");

    a_ev_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !w_evict |-> w_ev_key == '0)
        else $error("evicted key set without eviction");

    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !w_hit |-> w_hit_pos == '0 && w_occ != '0)
        else $error("bad position or empty list on a miss");

endmodule

bind lru_move_to_front_cache lmtf_checker #(.KEY_BITS(KEY_BITS)) u_lmtf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
